// ===== design/text_word_tokenizer_macros.svh =====
// Assertion macros used by the checker file of the word tokenizer.
`ifndef TEXT_WORD_TOKENIZER_MACROS_SVH
`define TEXT_WORD_TOKENIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWT_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tw_pkg.sv =====
// Shared types, codes and byte tables of the word tokenizer.
package tw_pkg;

    localparam logic [2:0] EV_WORD_BYTE = 3'd0;
    localparam logic [2:0] EV_WORD_END  = 3'd1;
    localparam logic [2:0] EV_SENTENCE  = 3'd2;
    localparam logic [2:0] EV_PARAGRAPH = 3'd3;
    localparam logic [2:0] EV_END       = 3'd4;

    typedef enum logic [2:0] {
        MODE_SEP  = 3'b001,
        MODE_WORD = 3'b010,
        MODE_DONE = 3'b100
    } tw_mode_t;

    typedef struct packed {
        tw_mode_t   mode;
        logic       pend;
        logic       per;
        logic [4:0] sig;
    } tw_state_t;

    localparam tw_state_t ST_RESET = '{mode: MODE_SEP, pend: 1'b0, per: 1'b0, sig: 5'd0};

    typedef struct packed {
        logic sep;
        logic digit;
        logic tilde;
        logic para;
        logic space;
        logic dot;
        logic stop;
    } tw_cls_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
        tw_cls_t    cls;
    } tw_req_t;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] ch;
    } tw_evt_t;

    localparam logic [7:0] SIG_TABLE [32] = '{
        8'h7E, 8'h60, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h2B, 8'h7C, 8'h3D,
        8'h2D, 8'h54, 8'h65, 8'h43, 8'h66, 8'h4D, 8'h74, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [7:0] sig_byte(input logic [4:0] idx);
        return SIG_TABLE[idx];
    endfunction

    function automatic tw_cls_t classify(input logic [7:0] b);
        tw_cls_t c;
        c.sep   = b inside {8'h7E, 8'h60, 8'h23, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
                            8'h29, 8'h2D, 8'h2B, 8'h3D, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
                            8'h3A, 8'h22, 8'h3B, 8'h27, 8'h3C, 8'h3E, 8'h3F, 8'h2C,
                            8'h2E, 8'h2F, 8'h5C, 8'h20, 8'h0D, 8'h0A, 8'hFF, 8'h09,
                            8'hB6, 8'h00};
        c.digit = b inside {[8'h30:8'h39]};
        c.tilde = (b == 8'h7E);
        c.para  = (b == 8'hB6);
        c.space = (b == 8'h20);
        c.dot   = (b == 8'h2E);
        c.stop  = (b == 8'h2E) || (b == 8'h3F);
        return c;
    endfunction

endpackage

// ===== design/tw_front.sv =====
// Input side of the word tokenizer: takes text bytes and classifies them into the queue.
module tw_front (
    input  logic            text_valid,
    output logic            text_ready,
    input  logic [7:0]      text_byte,
    input  logic            final_byte,
    input  logic            q_full,
    output logic            q_push,
    output tw_pkg::tw_req_t q_wdata
);
    import tw_pkg::*;

    assign text_ready = !q_full;
    assign q_push     = text_valid && !q_full;

    always_comb
    begin
        q_wdata.text_byte  = text_byte;
        q_wdata.final_byte = final_byte;
        q_wdata.cls        = classify(text_byte);
    end

endmodule

// ===== design/tw_queue.sv =====
// Two-entry request queue between the classifier and the tokenizing sequencer.
module tw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tw_pkg::tw_req_t wdata,
    output logic            full,
    input  logic            pop,
    output tw_pkg::tw_req_t rdata,
    output logic            empty
);
    import tw_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    tw_req_t    mem_reg [2];

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/tw_back.sv =====
// Tokenizing sequencer: applies the word, sentence and signature rules and emits results.
module tw_back #(
    parameter int unsigned SIGNATURE_LENGTH = 23
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  tw_pkg::tw_req_t q_data,
    output logic            q_pop,
    output logic            event_valid,
    input  logic            event_ready,
    output logic [2:0]      event_res,
    output logic [7:0]      word_char,
    output logic            run_end
);
    import tw_pkg::*;

    localparam logic [5:0] SIG_LEN = 6'(SIGNATURE_LENGTH);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_REPLAY = 6'b000010,
        PH_MAIN   = 6'b000100,
        PH_FLUSH  = 6'b001000,
        PH_SIGEND = 6'b010000,
        PH_FIN    = 6'b100000
    } phase_t;

    typedef struct packed {
        tw_state_t     st;
        logic [1:0]    n;
        tw_evt_t [1:0] evs;
    } sep_res_t;

    phase_t     phase_reg, phase_next;
    tw_state_t  st_reg, st_next;
    logic [4:0] rep_cnt_reg, rep_cnt_next;
    logic [4:0] rep_idx_reg, rep_idx_next;
    logic       after_rep_reg, after_rep_next;
    logic [1:0] ev_idx_reg, ev_idx_next;
    logic       hold_vld_reg, hold_vld_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    tw_cls_t    cls_reg, cls_next;
    tw_evt_t    hold_reg, hold_next;
    tw_evt_t    out_evt_reg, out_evt_next;
    logic       out_end_reg, out_end_next;

    logic [7:0]    op_byte;
    tw_cls_t       op_cls;
    logic          op_sig_ok;
    logic [1:0]    op_n;
    tw_evt_t [2:0] op_evs;
    tw_state_t     op_st;
    logic          op_last_ev;
    logic          out_free;
    logic          adv;
    logic          emit;
    tw_evt_t       emit_evt;

    function automatic tw_evt_t mk_evt(input logic [2:0] ev, input logic [7:0] ch);
        tw_evt_t e;
        e.ev = ev;
        e.ch = ch;
        return e;
    endfunction

    // Handling of one byte while between words.
    function automatic sep_res_t sep_fn(input tw_state_t s, input logic [7:0] b,
                                        input tw_cls_t c, input logic sig_ok);
        sep_res_t r;
        r.st  = s;
        r.n   = 2'd0;
        r.evs = '0;
        if (c.tilde && sig_ok)
        begin
            if (SIGNATURE_LENGTH <= 1)
            begin
                r.evs[0]   = mk_evt(EV_END, 8'h00);
                r.n        = 2'd1;
                r.st       = ST_RESET;
                r.st.mode  = MODE_DONE;
            end
            else
            begin
                r.st.sig = 5'd1;
            end
        end
        else if (c.para)
        begin
            r.evs[0]  = mk_evt(EV_PARAGRAPH, 8'h00);
            r.n       = 2'd1;
            r.st.pend = 1'b0;
        end
        else if (c.space)
        begin
            if (s.pend)
            begin
                r.evs[0]  = mk_evt(EV_SENTENCE, 8'h00);
                r.n       = 2'd1;
                r.st.pend = 1'b0;
            end
        end
        else if (c.stop)
        begin
            r.st.pend = 1'b1;
        end
        else if (c.tilde)
        begin
            r.st = s;
        end
        else if (c.sep)
        begin
            r.st.pend = 1'b0;
        end
        else
        begin
            if (s.pend)
            begin
                r.evs[0] = mk_evt(EV_SENTENCE, 8'h00);
                r.evs[1] = mk_evt(EV_WORD_BYTE, b);
                r.n      = 2'd2;
            end
            else
            begin
                r.evs[0] = mk_evt(EV_WORD_BYTE, b);
                r.n      = 2'd1;
            end
            r.st.mode = MODE_WORD;
            r.st.pend = 1'b0;
            r.st.per  = 1'b0;
        end
        return r;
    endfunction

    // Results and next state of the current step; results leave one per cycle unless the result side stalls.
    always_comb
    begin
        sep_res_t  sr;
        tw_state_t t;
        sr     = '0;
        t      = st_reg;
        op_n   = 2'd0;
        op_evs = '0;
        op_st  = st_reg;
        if (phase_reg == PH_REPLAY)
        begin
            op_byte   = sig_byte(rep_idx_reg);
            op_cls    = classify(op_byte);
            op_sig_ok = 1'b0;
        end
        else
        begin
            op_byte   = byte_reg;
            op_cls    = cls_reg;
            op_sig_ok = 1'b1;
        end
        case (phase_reg)
            PH_REPLAY, PH_MAIN:
            begin
                if (st_reg.mode != MODE_WORD)
                begin
                    sr        = sep_fn(st_reg, op_byte, op_cls, op_sig_ok);
                    op_st     = sr.st;
                    op_n      = sr.n;
                    op_evs[0] = sr.evs[0];
                    op_evs[1] = sr.evs[1];
                end
                else if (st_reg.per)
                begin
                    if (op_cls.digit)
                    begin
                        op_evs[0] = mk_evt(EV_WORD_BYTE, 8'h2E);
                        op_evs[1] = mk_evt(EV_WORD_BYTE, op_byte);
                        op_n      = 2'd2;
                        op_st.per = 1'b0;
                    end
                    else
                    begin
                        // The held period closes the word and then counts as a stop.
                        t.mode    = MODE_SEP;
                        t.pend    = 1'b1;
                        t.per     = 1'b0;
                        sr        = sep_fn(t, op_byte, op_cls, op_sig_ok);
                        op_st     = sr.st;
                        op_evs[0] = mk_evt(EV_WORD_END, 8'h00);
                        op_evs[1] = sr.evs[0];
                        op_evs[2] = sr.evs[1];
                        op_n      = 2'd1 + sr.n;
                    end
                end
                else if (!op_cls.sep)
                begin
                    op_evs[0] = mk_evt(EV_WORD_BYTE, op_byte);
                    op_n      = 2'd1;
                end
                else if (op_cls.dot)
                begin
                    op_st.per = 1'b1;
                end
                else
                begin
                    t.mode    = MODE_SEP;
                    t.pend    = 1'b0;
                    sr        = sep_fn(t, op_byte, op_cls, op_sig_ok);
                    op_st     = sr.st;
                    op_evs[0] = mk_evt(EV_WORD_END, 8'h00);
                    op_evs[1] = sr.evs[0];
                    op_evs[2] = sr.evs[1];
                    op_n      = 2'd1 + sr.n;
                end
            end
            PH_FLUSH:
            begin
                if (st_reg.mode == MODE_WORD)
                begin
                    op_evs[0] = mk_evt(EV_WORD_END, 8'h00);
                    op_evs[1] = mk_evt(EV_END, 8'h00);
                    op_n      = 2'd2;
                end
                else
                begin
                    op_evs[0] = mk_evt(EV_END, 8'h00);
                    op_n      = 2'd1;
                end
                op_st = ST_RESET;
            end
            PH_SIGEND:
            begin
                op_evs[0] = mk_evt(EV_END, 8'h00);
                op_n      = 2'd1;
                op_st     = ST_RESET;
                if (!last_reg)
                begin
                    op_st.mode = MODE_DONE;
                end
            end
            default:
            begin
                op_n = 2'd0;
            end
        endcase
    end

    assign out_free   = !out_vld_reg || event_ready;
    assign adv        = !hold_vld_reg || out_free;
    assign op_last_ev = (op_n == 2'd0) || (ev_idx_reg == (op_n - 2'd1));
    assign emit_evt   = op_evs[ev_idx_reg];

    always_comb
    begin
        phase_next     = phase_reg;
        st_next        = st_reg;
        rep_cnt_next   = rep_cnt_reg;
        rep_idx_next   = rep_idx_reg;
        after_rep_next = after_rep_reg;
        ev_idx_next    = ev_idx_reg;
        hold_vld_next  = hold_vld_reg;
        hold_next      = hold_reg;
        out_vld_next   = out_vld_reg;
        out_evt_next   = out_evt_reg;
        out_end_next   = out_end_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        cls_next       = cls_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;

        if (out_vld_reg && event_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    byte_next    = q_data.text_byte;
                    last_next    = q_data.final_byte;
                    cls_next     = q_data.cls;
                    ev_idx_next  = 2'd0;
                    rep_idx_next = 5'd0;
                    if (st_reg.mode == MODE_DONE)
                    begin
                        // After a full signature only the last byte matters.
                        if (q_data.final_byte)
                        begin
                            st_next = ST_RESET;
                        end
                        phase_next = PH_FIN;
                    end
                    else if (st_reg.sig != 5'd0)
                    begin
                        if (q_data.text_byte == sig_byte(st_reg.sig))
                        begin
                            if (({1'b0, st_reg.sig} + 6'd1) >= SIG_LEN)
                            begin
                                phase_next = PH_SIGEND;
                            end
                            else if (!q_data.final_byte)
                            begin
                                st_next.sig = st_reg.sig + 5'd1;
                                phase_next  = PH_FIN;
                            end
                            else
                            begin
                                rep_cnt_next   = st_reg.sig + 5'd1;
                                st_next.sig    = 5'd0;
                                after_rep_next = 1'b1;
                                phase_next     = PH_REPLAY;
                            end
                        end
                        else
                        begin
                            rep_cnt_next   = st_reg.sig;
                            st_next.sig    = 5'd0;
                            after_rep_next = 1'b0;
                            phase_next     = PH_REPLAY;
                        end
                    end
                    else
                    begin
                        phase_next = PH_MAIN;
                    end
                end
            end
            PH_REPLAY, PH_MAIN, PH_FLUSH, PH_SIGEND:
            begin
                if (adv)
                begin
                    emit = (op_n != 2'd0);
                    if (op_last_ev)
                    begin
                        ev_idx_next = 2'd0;
                        st_next     = op_st;
                        case (phase_reg)
                            PH_REPLAY:
                            begin
                                if ((rep_idx_reg + 5'd1) == rep_cnt_reg)
                                begin
                                    phase_next = after_rep_reg ? PH_FLUSH : PH_MAIN;
                                end
                                else
                                begin
                                    rep_idx_next = rep_idx_reg + 5'd1;
                                end
                            end
                            PH_MAIN:
                            begin
                                if (op_st.mode == MODE_DONE)
                                begin
                                    if (last_reg)
                                    begin
                                        st_next = ST_RESET;
                                    end
                                    phase_next = PH_FIN;
                                end
                                else if (last_reg)
                                begin
                                    if (op_st.sig != 5'd0)
                                    begin
                                        // A signature cut short by the last byte.
                                        rep_cnt_next   = op_st.sig;
                                        rep_idx_next   = 5'd0;
                                        st_next.sig    = 5'd0;
                                        after_rep_next = 1'b1;
                                        phase_next     = PH_REPLAY;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FLUSH;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_FIN;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_FIN;
                            end
                        endcase
                    end
                    else
                    begin
                        ev_idx_next = ev_idx_reg + 2'd1;
                    end
                end
            end
            PH_FIN:
            begin
                if (adv)
                begin
                    if (hold_vld_reg)
                    begin
                        out_vld_next = 1'b1;
                        out_evt_next = hold_reg;
                        out_end_next = 1'b1;
                    end
                    hold_vld_next = 1'b0;
                    phase_next    = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // One result is held back so that the last one of a request can be marked.
        if (emit)
        begin
            if (hold_vld_reg)
            begin
                out_vld_next = 1'b1;
                out_evt_next = hold_reg;
                out_end_next = 1'b0;
            end
            hold_next     = emit_evt;
            hold_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            st_reg        <= ST_RESET;
            rep_cnt_reg   <= 5'd0;
            rep_idx_reg   <= 5'd0;
            after_rep_reg <= 1'b0;
            ev_idx_reg    <= 2'd0;
            hold_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            st_reg        <= st_next;
            rep_cnt_reg   <= rep_cnt_next;
            rep_idx_reg   <= rep_idx_next;
            after_rep_reg <= after_rep_next;
            ev_idx_reg    <= ev_idx_next;
            hold_vld_reg  <= hold_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        cls_reg     <= cls_next;
        hold_reg    <= hold_next;
        out_evt_reg <= out_evt_next;
        out_end_reg <= out_end_next;
    end

    assign event_valid = out_vld_reg;
    assign event_res   = out_evt_reg.ev;
    assign word_char   = out_evt_reg.ch;
    assign run_end     = out_end_reg;

endmodule

// ===== design/text_word_tokenizer.sv =====
// Top level of the word tokenizer: classifier, request queue and tokenizing sequencer.
//
// Splits a text byte stream into word bytes, word ends, sentence ends, paragraph marks
// and an end-of-buffer result, one text byte per request. A two-entry queue decouples
// the input from the sequencer, so bytes keep flowing in while results are delivered.
// The sequencer handles one request at a time: a request that runs through the word
// rules is taken from the queue, emits its results one by one, and then finishes,
// even when it has no result. A byte that extends an end-signature match, or that
// arrives after a full match, is taken and finished without a result step.
// When an end-signature match fails, the held prefix of k bytes is replayed from the
// signature table, one byte per step, before the failing byte itself is handled.
// The last result of each request is marked by run_end, so one result is held back in
// the sequencer ahead of the output register; while the result side stalls, the
// sequencer goes on only until both of them are full.
module text_word_tokenizer #(
    parameter int unsigned SIGNATURE_LENGTH = 23
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       event_valid,
    input  logic       event_ready,
    output logic [2:0] event_res,
    output logic [7:0] word_char,
    output logic       run_end
);
    import tw_pkg::*;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    tw_req_t q_wdata;
    tw_req_t q_rdata;

    tw_front u_front (
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    tw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    tw_back #(
        .SIGNATURE_LENGTH (SIGNATURE_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_res   (event_res),
        .word_char   (word_char),
        .run_end     (run_end)
    );

endmodule

// ===== design/tw_checker.sv =====
// Port-level checks of the word tokenizer and their binding to the top level.
`include "text_word_tokenizer_macros.svh"

module tw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       event_valid,
    input logic       event_ready,
    input logic [2:0] event_res,
    input logic [7:0] word_char,
    input logic       run_end
);
    import tw_pkg::*;

    `TWT_ASSERT_NEXT(a_out_hold, event_valid && !event_ready, event_valid, "result dropped while stalled")
    `TWT_ASSERT_NEXT(a_out_stable, event_valid && !event_ready, $stable(event_res) && $stable(word_char) && $stable(run_end), "result changed while stalled")
    `TWT_ASSERT_HOLDS(a_end_closes_run, event_valid && (event_res == EV_END), run_end, "end of buffer is not the last result of its request")
    `TWT_ASSERT_HOLDS(a_char_only_on_word, event_valid && (event_res != EV_WORD_BYTE), word_char == 8'h00, "character on a result that is not a word byte")

endmodule

bind text_word_tokenizer tw_checker u_tw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_res   (event_res),
    .word_char   (word_char),
    .run_end     (run_end)
);

// ===== test/token_stream_check.sv =====
// Result checker for the word tokenizer: predicts tokens per accepted byte and compares them.
`timescale 1ns / 100ps

module token_stream_check #(
    parameter int SIG_LEN = 23
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    input  logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    input  logic       event_valid,
    input  logic       event_ready,
    input  logic [2:0] event_res,
    input  logic [7:0] word_char,
    input  logic       run_end,
    output int         fail_count,
    output int         pending,
    output int         n_results,
    output int         n_ends
);
    import tw_pkg::*;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] ch;
        logic       fin;
    } token_t;

    localparam int MAX_PER_BYTE = 48;
    localparam logic [7:0] DOT     = 8'h2E;
    localparam logic [7:0] QMARK   = 8'h3F;
    localparam logic [7:0] SPACE   = 8'h20;
    localparam logic [7:0] TILDE   = 8'h7E;
    localparam logic [7:0] PILCROW = 8'hB6;

    // End signature "~`!@#$%^&*()-+|=-TeCfMt", first byte in the top bits.
    localparam logic [8*23-1:0] END_SIG = {
        8'h7E, 8'h60, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h2B, 8'h7C, 8'h3D,
        8'h2D, 8'h54, 8'h65, 8'h43, 8'h66, 8'h4D, 8'h74
    };

    tw_mode_t    tok_mode;
    logic        sent_pending;
    logic        dot_held;
    int unsigned sig_held;

    token_t byte_tokens[$];
    token_t expected_tokens[$];

    function automatic logic [7:0] sig_char(input int unsigned k);
        if (k < 23)
            return END_SIG[(22 - k) * 8 +: 8];
        return 8'h00;
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        case (b)
            8'h7E, 8'h60, 8'h23, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
            8'h2D, 8'h2B, 8'h3D, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3A, 8'h22,
            8'h3B, 8'h27, 8'h3C, 8'h3E, 8'h3F, 8'h2C, 8'h2E, 8'h2F, 8'h5C,
            8'h20, 8'h0D, 8'h0A, 8'hFF, 8'h09, 8'hB6, 8'h00: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void put_token(input logic [2:0] ev, input logic [7:0] ch);
        token_t t;
        if (byte_tokens.size() < MAX_PER_BYTE)
        begin
            t.ev  = ev;
            t.ch  = (ev == EV_WORD_BYTE) ? ch : 8'h00;
            t.fin = 1'b0;
            byte_tokens.push_back(t);
        end
    endfunction

    function automatic void reset_scan();
        tok_mode     = MODE_SEP;
        sent_pending = 1'b0;
        dot_held     = 1'b0;
        sig_held     = 0;
    endfunction

    function automatic void scan_separator(input logic [7:0] b, input logic sig_ok);
        if (b == TILDE && sig_ok)
        begin
            if (SIG_LEN <= 1)
            begin
                put_token(EV_END, 8'h00);
                reset_scan();
                tok_mode = MODE_DONE;
            end
            else
                sig_held = 1;
        end
        else if (b == PILCROW)
        begin
            put_token(EV_PARAGRAPH, 8'h00);
            sent_pending = 1'b0;
        end
        else if (b == SPACE)
        begin
            if (sent_pending)
            begin
                put_token(EV_SENTENCE, 8'h00);
                sent_pending = 1'b0;
            end
        end
        else if (b == DOT || b == QMARK)
            sent_pending = 1'b1;
        else if (b == TILDE)
        begin
            // A tilde that cannot open a match keeps any pending sentence end.
        end
        else if (is_separator(b))
            sent_pending = 1'b0;
        else
        begin
            if (sent_pending)
            begin
                put_token(EV_SENTENCE, 8'h00);
                sent_pending = 1'b0;
            end
            put_token(EV_WORD_BYTE, b);
            tok_mode = MODE_WORD;
            dot_held = 1'b0;
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic sig_ok);
        if (tok_mode != MODE_WORD)
        begin
            scan_separator(b, sig_ok);
            return;
        end
        if (dot_held)
        begin
            dot_held = 1'b0;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                put_token(EV_WORD_BYTE, DOT);
                put_token(EV_WORD_BYTE, b);
            end
            else
            begin
                put_token(EV_WORD_END, 8'h00);
                tok_mode     = MODE_SEP;
                sent_pending = 1'b0;
                scan_separator(DOT, sig_ok);
                scan_separator(b, sig_ok);
            end
        end
        else if (!is_separator(b))
            put_token(EV_WORD_BYTE, b);
        else if (b == DOT)
            dot_held = 1'b1;
        else
        begin
            put_token(EV_WORD_END, 8'h00);
            tok_mode     = MODE_SEP;
            sent_pending = 1'b0;
            scan_separator(b, sig_ok);
        end
    endfunction

    function automatic void replay_prefix(input int unsigned count);
        sig_held = 0;
        for (int unsigned i = 0; i < count && i < 32; i++)
            scan_byte(sig_char(i), 1'b0);
    endfunction

    function automatic void close_buffer();
        if (tok_mode == MODE_WORD)
            put_token(EV_WORD_END, 8'h00);
        put_token(EV_END, 8'h00);
        reset_scan();
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        int unsigned k;
        logic        matched;
        token_t      t;
        byte_tokens.delete();
        matched = 1'b0;
        if (tok_mode == MODE_DONE)
        begin
            if (last)
                reset_scan();
        end
        else
        begin
            if (sig_held > 0)
            begin
                k = sig_held & 31;
                if (b == sig_char(k))
                begin
                    matched = 1'b1;
                    if (k + 1 >= SIG_LEN)
                    begin
                        put_token(EV_END, 8'h00);
                        reset_scan();
                        if (!last)
                            tok_mode = MODE_DONE;
                    end
                    else if (!last)
                        sig_held = k + 1;
                    else
                    begin
                        replay_prefix(k + 1);
                        close_buffer();
                    end
                end
                else
                begin
                    replay_prefix(k);
                    scan_byte(b, 1'b1);
                end
            end
            else
                scan_byte(b, 1'b1);

            if (!matched)
            begin
                if (tok_mode == MODE_DONE)
                begin
                    if (last)
                        reset_scan();
                end
                else if (last)
                begin
                    if (sig_held > 0)
                        replay_prefix(sig_held);
                    close_buffer();
                end
            end
        end
        foreach (byte_tokens[i])
        begin
            t     = byte_tokens[i];
            t.fin = (i == byte_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < 30)
            $display("[%0t] token mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_result();
        token_t want;
        n_results++;
        if (event_res == EV_END)
            n_ends++;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("result ev=%0d ch=%02h with none expected",
                                      event_res, word_char));
            return;
        end
        want = expected_tokens.pop_front();
        if (event_res !== want.ev)
            report_mismatch($sformatf("event_res %0d, want %0d", event_res, want.ev));
        if (word_char !== want.ch)
            report_mismatch($sformatf("word_char %02h, want %02h", word_char, want.ch));
        if (run_end !== want.fin)
            report_mismatch($sformatf("run_end %0b, want %0b", run_end, want.fin));
    endtask

    // Input side is handled first so a byte's tokens are queued before any compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_scan();
            expected_tokens.delete();
            pending <= 0;
        end
        else
        begin
            if (text_valid && text_ready)
                predict_byte(text_byte, final_byte);
            if (event_valid && event_ready)
                check_result();
            pending <= expected_tokens.size();
        end
    end

endmodule

// ===== test/tb_text_word_tokenizer.sv =====
// Testbench top for the word tokenizer: clock, reset, byte stimulus, result drain and verdict.
`timescale 1ns / 100ps

module tb_text_word_tokenizer;
    import tw_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BYTES  = 160;

    localparam logic [7:0] DOT     = 8'h2E;
    localparam logic [7:0] QMARK   = 8'h3F;
    localparam logic [7:0] SPACE   = 8'h20;
    localparam logic [7:0] TILDE   = 8'h7E;
    localparam logic [7:0] PILCROW = 8'hB6;

    logic       clk;
    logic       rst_n;
    logic       text_valid;
    logic       text_ready;
    logic [7:0] text_byte;
    logic       final_byte;
    logic       event_valid;
    logic       event_ready;
    logic [2:0] event_res;
    logic [7:0] word_char;
    logic       run_end;

    int fail_count;
    int pending;
    int n_results;
    int n_ends;

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;
    logic hold_done;
    int   bytes_sent;
    int   buffers_sent;
    int   quiet_cycles;

    logic [7:0] text_buf[$];
    logic [8:0] opening_text[$];

    text_word_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .event_valid(event_valid),
        .event_ready(event_ready),
        .event_res  (event_res),
        .word_char  (word_char),
        .run_end    (run_end)
    );

    token_stream_check token_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .event_valid(event_valid),
        .event_ready(event_ready),
        .event_res  (event_res),
        .word_char  (word_char),
        .run_end    (run_end),
        .fail_count (fail_count),
        .pending    (pending),
        .n_results  (n_results),
        .n_ends     (n_ends)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Result side: random back-pressure, plus one long hold-off when asked for.
    always
    begin
        @(posedge clk);
        if (rst_n && hold_req && !hold_done)
        begin
            event_ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        else
            event_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && text_ready) || (event_valid && event_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("No request moved for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, pending);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_word_byte();
        case ($urandom_range(0, 4))
            0: return 8'(8'h61 + $urandom_range(0, 25));
            1: return 8'(8'h41 + $urandom_range(0, 25));
            2: return 8'(8'h30 + $urandom_range(0, 9));
            3: return 8'($urandom_range(8'h80, 8'hFE));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 10))
            0: return SPACE;
            1: return DOT;
            2: return QMARK;
            3: return 8'h2C;
            4: return 8'h0A;
            5: return 8'h0D;
            6: return 8'h09;
            7: return 8'h00;
            8: return 8'hFF;
            9: return 8'h2D;
            default: return TILDE;
        endcase
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_text(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        bytes_sent++;
        if (fin)
            buffers_sent++;
    endtask

    // Mostly well-formed text: words, decimals, sentence stops, paragraphs and
    // end signatures (whole, broken, or cut off by the end of the buffer).
    task automatic build_buffer(output int ignored);
        int   len;
        int   kind;
        logic stop;
        text_buf.delete();
        ignored = 0;
        stop    = 1'b0;
        repeat ($urandom_range(2, 10))
        begin
            if (!stop)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                begin
                    repeat ($urandom_range(1, 8))
                        text_buf.push_back(pick_word_byte());
                end
                else if (kind < 42)
                begin
                    repeat ($urandom_range(1, 3))
                        text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
                    text_buf.push_back(DOT);
                    if ($urandom_range(0, 2) != 0)
                        text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
                    else
                        text_buf.push_back(pick_word_byte());
                end
                else if (kind < 52)
                begin
                    text_buf.push_back($urandom_range(0, 1) ? DOT : QMARK);
                    text_buf.push_back($urandom_range(0, 1) ? SPACE : pick_word_byte());
                end
                else if (kind < 62)
                begin
                    repeat ($urandom_range(1, 3))
                        text_buf.push_back(pick_separator());
                end
                else if (kind < 67)
                    text_buf.push_back(PILCROW);
                else if (kind < 75)
                begin
                    len = $urandom_range(1, 22);
                    for (int k = 0; k < len; k++)
                        text_buf.push_back(SIG_TABLE[k]);
                    if ($urandom_range(0, 3) == 0)
                        stop = 1'b1;
                    else
                        text_buf.push_back(8'($urandom_range(0, 255)));
                end
                else if (kind < 83)
                begin
                    for (int k = 0; k < 23; k++)
                        text_buf.push_back(SIG_TABLE[k]);
                    // Bytes after a matched signature only wait for the buffer end.
                    ignored = $urandom_range(0, 3);
                    repeat (ignored)
                        text_buf.push_back(8'($urandom_range(0, 255)));
                    stop = 1'b1;
                end
                else
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_buffer();
        int ignored;
        build_buffer(ignored);
        foreach (text_buf[i])
            send_text(text_buf[i], i == text_buf.size() - 1);
        bytes_sent -= ignored;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        text_valid    = 1'b0;
        text_byte     = 8'h00;
        final_byte    = 1'b0;
        event_ready   = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        quiet_cycles  = 0;
        bytes_sent    = 0;
        buffers_sent  = 0;
        send_idle_pct = 36;
        recv_idle_pct = 87;

        // {last flag, byte}: word extremes, a decimal point, a period before a
        // letter, a question mark and space, a paragraph mark, a broken signature,
        // a tilde that keeps a pending sentence end, a signature cut by the last
        // byte, a held period at the last byte, and a one-byte buffer.
        opening_text = '{9'h041, 9'h001, 9'h02E, 9'h037, 9'h02E, 9'h07A, 9'h03F,
                         9'h020, 9'h0B6, 9'h0FE, 9'h000, 9'h07E, 9'h060, 9'h021,
                         9'h071, 9'h02E, 9'h07E, 9'h078, 9'h07E, 9'h160, 9'h077,
                         9'h12E, 9'h180};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_text[i])
            send_text(opening_text[i][7:0], opening_text[i][8]);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            while (bytes_sent < PHASE_BYTES * (phase + 1))
                send_buffer();
        end

        text_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        $display("Covered %0d text bytes in %0d buffers, three idle mixes, a %0d-cycle stall.",
                 bytes_sent, buffers_sent, HOLD_CYCLES);
        $display("Compared %0d results, %0d of them end-of-buffer.", n_results, n_ends);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
